// ===== design/tgbp_pkg.sv =====
`default_nettype none
package tgbp_pkg;

	localparam int TABLES = 4;
	localparam int MAX_TAG_BITS = 9;
	localparam int COUNTER_BITS = 3;
	localparam int HISTORY_BITS = 131;
	localparam int PATH_BITS = 16;
	localparam int SEED_BITS = 2 * TABLES;
	localparam int TICK_BITS = 19;
	localparam int AGING_PERIOD_BITS = 18;
	localparam int USE_ALT_BITS = 4;
	localparam int PROVIDER_BITS = 3;
	localparam logic [31:0] SEED_ADDEND = 32'h00f3_f531;

	// Geometric history lengths, longest first.
	localparam int HIST_LEN [TABLES] = '{130, 44, 15, 5};

	typedef struct packed {
		logic [31:0] pc;
		logic        is_conditional;
		logic        taken;
	} request_t;

	typedef struct packed {
		logic                     predicted_taken;
		logic [PROVIDER_BITS-1:0] provider_table;
		logic                     alternate_taken;
	} result_t;

	typedef struct packed {
		logic [COUNTER_BITS-1:0] ctr;
		logic [MAX_TAG_BITS-1:0] tag;
		logic [1:0]              useful;
	} tag_entry_t;

	function automatic int tag_width(input int t);
		return MAX_TAG_BITS - ((t + (TABLES % 2)) / 2);
	endfunction

	function automatic logic [31:0] shr32(input logic [31:0] v, input int s);
		logic [31:0] r;
		if (s <= 0) begin
			r = v;
		end else if (s >= 32) begin
			r = '0;
		end else begin
			r = v >> s;
		end
		return r;
	endfunction

	// One step of a circular folded history register of clen bits.
	function automatic logic [31:0] fold32(input logic [31:0] c, input int clen,
			input logic newest, input logic oldest, input int rot);
		logic [31:0] v;
		v = (c << 1) | {31'd0, newest};
		v = v ^ ({31'd0, oldest} << rot);
		v = v ^ (v >> clen);
		return v & ((32'd1 << clen) - 32'd1);
	endfunction

endpackage
`default_nettype wire

// ===== design/tagged_geometric_branch_predictor_unit.sv =====
// Branch direction predictor with four tagged tables over a bimodal base.
// Requests enter through push/full: one request is one branch (pc, conditional
// flag, resolved outcome) and is taken at a clock edge with push high and full low.
// Results leave through empty/pop in request order, one per request: the
// prediction made before training, the providing table (4 for the bimodal base)
// and the alternate prediction. Unconditional requests give an all-zero result
// and only advance the histories.
// The front stage hashes indexes and tags and shifts the histories in the cycle
// a request is taken; a two-entry queue feeds the back stage. The back stage
// reads the tables in its idle state and predicts and writes back in its
// execute state for a conditional request, and answers an unconditional one
// from the idle state alone, so it takes no new conditional branch before it
// is through with the last one. Every 2^18 conditional branches the back stage
// sweeps all tagged entries to age the useful bits. After reset the tables are
// cleared, one row per cycle over every row of the bimodal and tagged tables;
// full stays high meanwhile. When pop stays low, results wait in a two-entry
// output queue and the back stage stalls, then the input queue fills and full rises.
`default_nettype none
module tagged_geometric_branch_predictor_unit #(
	parameter int BIMODAL_INDEX_BITS = 13,
	parameter int TAGGED_INDEX_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output      logic               full,
	input  wire tgbp_pkg::request_t request,
	output      logic               empty,
	input  wire logic               pop,
	output      tgbp_pkg::result_t  result
);
	import tgbp_pkg::*;

	typedef struct packed {
		logic                                         cond;
		logic                                         taken;
		logic [BIMODAL_INDEX_BITS-1:0]                bidx;
		logic [TABLES-1:0][TAGGED_INDEX_BITS-1:0]     idx;
		logic [TABLES-1:0][MAX_TAG_BITS-1:0]          tag;
		logic [SEED_BITS-1:0]                         rnd;
		logic                                         sweep;
		logic [1:0]                                   keep;
	} item_t;

	logic    accept;
	logic    mid_push, mid_full, mid_empty, mid_pop;
	item_t   mid_in, mid_out;
	logic    out_push, out_full;
	result_t out_data;
	logic    clearing;

	assign full   = mid_full || clearing;
	assign accept = push && !full;

	tgbp_front #(
		.BIMODAL_INDEX_BITS (BIMODAL_INDEX_BITS),
		.TAGGED_INDEX_BITS  (TAGGED_INDEX_BITS),
		.item_t             (item_t)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.mid_push (mid_push),
		.mid_item (mid_in)
	);

	tgbp_fifo #(.T(item_t), .DEPTH(2)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	tgbp_back #(
		.BIMODAL_INDEX_BITS (BIMODAL_INDEX_BITS),
		.TAGGED_INDEX_BITS  (TAGGED_INDEX_BITS),
		.item_t             (item_t)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_empty),
		.mid_item  (mid_out),
		.mid_pop   (mid_pop),
		.out_push  (out_push),
		.out_data  (out_data),
		.out_full  (out_full),
		.clearing  (clearing)
	);

	tgbp_fifo #(.T(result_t), .DEPTH(2)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_data),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire

// ===== design/tgbp_ram.sv =====
`default_nettype none
module tgbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/tgbp_fifo.sv =====
`default_nettype none
module tgbp_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     din,
	output      logic full,
	input  wire logic pop,
	output      T     dout,
	output      logic empty
);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/tgbp_front.sv =====
`default_nettype none
module tgbp_front #(
	parameter int BIMODAL_INDEX_BITS = 13,
	parameter int TAGGED_INDEX_BITS = 10,
	parameter type item_t = logic
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire tgbp_pkg::request_t request,
	output      logic               mid_push,
	output      item_t              mid_item
);
	import tgbp_pkg::*;

	localparam int TIB = TAGGED_INDEX_BITS;
	localparam int TN = TABLES;
	localparam logic [31:0] IDX_MASK = (32'd1 << TIB) - 32'd1;

	logic [HISTORY_BITS-1:0]   ghist_q;
	logic [HISTORY_BITS-1:0]   ghist_d;
	logic [PATH_BITS-1:0]      path_q;
	logic [TIB-1:0]            fih_q [TN];
	logic [TIB-1:0]            fih_d [TN];
	logic [MAX_TAG_BITS-1:0]   fta_q [TN];
	logic [MAX_TAG_BITS-1:0]   fta_d [TN];
	logic [MAX_TAG_BITS-2:0]   ftb_q [TN];
	logic [MAX_TAG_BITS-2:0]   ftb_d [TN];
	logic [SEED_BITS-1:0]      seed_q;
	logic [SEED_BITS-1:0]      seed_d;
	logic [TICK_BITS-1:0]      tick_q;
	logic [TICK_BITS-1:0]      tick_d;
	logic [TIB-1:0]            idx_w [TN];
	logic [MAX_TAG_BITS-1:0]   tag_w [TN];
	logic                      hist_bit;

	assign hist_bit = !request.is_conditional || request.taken;
	assign ghist_d  = {ghist_q[HISTORY_BITS-2:0], hist_bit};
	// 257 * seed is seed modulo 256, so the generator reduces to an add.
	assign seed_d   = seed_q + SEED_ADDEND[SEED_BITS-1:0];
	assign tick_d   = request.is_conditional ? tick_q + 1'b1 : tick_q;
	assign mid_push = accept;

	for (genvar t = 0; t < TN; t++) begin : g_tab
		localparam int HL  = HIST_LEN[t];
		localparam int TWD = tag_width(t);
		localparam int SZ  = (HL >= PATH_BITS) ? PATH_BITS : HL;
		localparam int RI  = HL % TIB;
		localparam int RA  = HL % TWD;
		localparam int RB  = HL % (TWD - 1);
		localparam int SH  = TIB - (TN - t - 1);
		localparam logic [31:0] TAG_MASK = (32'd1 << TWD) - 32'd1;
		localparam logic [31:0] SZ_MASK  = (32'd1 << SZ) - 32'd1;

		logic [31:0] a;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] pmix;
		logic [31:0] iv;
		logic [31:0] tv;

		always_comb begin
			a    = {16'd0, path_q} & SZ_MASK;
			lo   = a & IDX_MASK;
			hi   = a >> TIB;
			hi   = ((hi << t) & IDX_MASK) + shr32(hi, TIB - t);
			a    = lo ^ hi;
			pmix = ((a << t) & IDX_MASK) + shr32(a, TIB - t);
			iv   = request.pc ^ shr32(request.pc, SH) ^ 32'(fih_q[t]) ^ pmix;
			tv   = (request.pc ^ 32'(fta_q[t]) ^ (32'(ftb_q[t]) << 1)) & TAG_MASK;
		end

		assign idx_w[t] = iv[TIB-1:0];
		assign tag_w[t] = tv[MAX_TAG_BITS-1:0];
		assign fih_d[t] = TIB'(fold32(32'(fih_q[t]), TIB, ghist_d[0], ghist_d[HL], RI));
		assign fta_d[t] = MAX_TAG_BITS'(fold32(32'(fta_q[t]), TWD, ghist_d[0],
			ghist_d[HL], RA));
		assign ftb_d[t] = (MAX_TAG_BITS-1)'(fold32(32'(ftb_q[t]), TWD - 1, ghist_d[0],
			ghist_d[HL], RB));
	end

	always_comb begin
		mid_item.cond  = request.is_conditional;
		mid_item.taken = request.taken;
		mid_item.bidx  = request.pc[BIMODAL_INDEX_BITS-1:0];
		for (int t = 0; t < TN; t++) begin
			mid_item.idx[t] = idx_w[t];
			mid_item.tag[t] = tag_w[t];
		end
		mid_item.rnd   = seed_d;
		mid_item.sweep = request.is_conditional && (tick_d[AGING_PERIOD_BITS-1:0] == '0);
		mid_item.keep  = tick_d[AGING_PERIOD_BITS] ? 2'b01 : 2'b10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q <= '0;
			path_q  <= '0;
			seed_q  <= '0;
			tick_q  <= '0;
			for (int t = 0; t < TN; t++) begin
				fih_q[t] <= '0;
				fta_q[t] <= '0;
				ftb_q[t] <= '0;
			end
		end else if (accept) begin
			ghist_q <= ghist_d;
			path_q  <= {path_q[PATH_BITS-2:0], request.pc[0]};
			seed_q  <= seed_d;
			tick_q  <= tick_d;
			for (int t = 0; t < TN; t++) begin
				fih_q[t] <= fih_d[t];
				fta_q[t] <= fta_d[t];
				ftb_q[t] <= ftb_d[t];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/tgbp_back.sv =====
`default_nettype none
module tgbp_back #(
	parameter int BIMODAL_INDEX_BITS = 13,
	parameter int TAGGED_INDEX_BITS = 10,
	parameter type item_t = logic
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mid_valid,
	input  wire item_t             mid_item,
	output      logic              mid_pop,
	output      logic              out_push,
	output      tgbp_pkg::result_t out_data,
	input  wire logic              out_full,
	output      logic              clearing
);
	import tgbp_pkg::*;

	localparam int TIB  = TAGGED_INDEX_BITS;
	localparam int BRW  = BIMODAL_INDEX_BITS - 2;
	localparam int TN   = TABLES;
	localparam int TI   = $clog2(TN);
	localparam int ENT  = 1 << TIB;
	localparam int CLW  = (BRW > TIB) ? BRW : TIB;
	localparam int CB   = COUNTER_BITS;
	localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [PROVIDER_BITS-1:0] NONE = PROVIDER_BITS'(TN);
	localparam logic signed [USE_ALT_BITS-1:0] UA_MAX = 4'sd7;
	localparam logic signed [USE_ALT_BITS-1:0] UA_MIN = -4'sd8;
	// A bimodal row holds the shared hysteresis bit over four direction bits.
	localparam logic [4:0] BROW_RESET = 5'b10000;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	state_t                          state_q, state_d;
	logic [CLW-1:0]                  clr_q;
	logic [TIB:0]                    cnt_q, cnt_d;
	logic signed [USE_ALT_BITS-1:0]  uac_q, uac_d;
	logic [1:0]                      keep_q, keep_d;
	logic [PROVIDER_BITS-1:0]        skip_tab_q, skip_tab_d;
	logic [TIB-1:0]                  skip_addr_q, skip_addr_d;

	logic                            t_re;
	logic [TN-1:0]                   t_we;
	logic [TIB-1:0]                  t_ra [TN];
	logic [TIB-1:0]                  t_wa [TN];
	tag_entry_t                      t_wd [TN];
	tag_entry_t                      ent  [TN];
	logic                            b_re, b_we;
	logic [BRW-1:0]                  b_ra, b_wa;
	logic [4:0]                      b_wd, brow;

	for (genvar t = 0; t < TN; t++) begin : g_ram
		tgbp_ram #(.WIDTH($bits(tag_entry_t)), .DEPTH(ENT)) u_tab (
			.clk   (clk),
			.we    (t_we[t]),
			.waddr (t_wa[t]),
			.wdata (t_wd[t]),
			.re    (t_re),
			.raddr (t_ra[t]),
			.rdata (ent[t])
		);
	end

	tgbp_ram #(.WIDTH(5), .DEPTH(1 << BRW)) u_bim (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_wa),
		.wdata (b_wd),
		.re    (b_re),
		.raddr (b_ra),
		.rdata (brow)
	);

	// Prediction and update terms, valid in the execute state.
	logic [TN-1:0]            hit;
	logic [PROVIDER_BITS-1:0] bank, altb, tgt;
	logic                     found, althit, tgt_ok, any_zero;
	tag_entry_t               prov;
	logic                     bim, ctr_weak, loc, altp, pred, tk, alloc;
	logic [CB-1:0]            c_new;
	logic [1:0]               u_new;
	logic [4:0]               brow_new;
	logic [1:0]               bstate;
	int                       x;
	logic                     stop;

	always_comb begin
		tk = mid_item.taken;
		for (int t = 0; t < TN; t++) begin
			hit[t] = (ent[t].tag == mid_item.tag[t]);
		end
		bank = NONE;
		for (int t = TN - 1; t >= 0; t--) begin
			if (hit[t]) begin
				bank = PROVIDER_BITS'(t);
			end
		end
		altb = NONE;
		for (int t = TN - 1; t >= 0; t--) begin
			if (hit[t] && PROVIDER_BITS'(t) > bank) begin
				altb = PROVIDER_BITS'(t);
			end
		end
		found    = (bank != NONE);
		althit   = (altb != NONE);
		prov     = ent[bank[TI-1:0]];
		bim      = brow[mid_item.bidx[1:0]];
		ctr_weak = (prov.ctr == '0) || (prov.ctr == '1);
		loc      = !prov.ctr[CB-1];
		altp     = althit ? !ent[altb[TI-1:0]].ctr[CB-1] : bim;
		if (!found) begin
			pred = bim;
		end else if (uac_q < 0 || !ctr_weak || prov.useful != '0) begin
			pred = loc;
		end else begin
			pred = altp;
		end

		alloc = (pred != tk) && (bank != '0);
		uac_d = uac_q;
		if (found && ctr_weak && prov.useful == '0) begin
			if (loc == tk) begin
				alloc = 1'b0;
			end
			if (loc != altp) begin
				if (altp == tk) begin
					if (uac_q != UA_MAX) begin
						uac_d = uac_q + 4'sd1;
					end
				end else if (uac_q != UA_MIN) begin
					uac_d = uac_q - 4'sd1;
				end
			end
		end

		any_zero = 1'b0;
		for (int t = 0; t < TN; t++) begin
			if (PROVIDER_BITS'(t) < bank && ent[t].useful == '0) begin
				any_zero = 1'b1;
			end
		end

		// The random start skips one table per trailing one of the seed.
		x    = int'(bank) - 1;
		stop = 1'b0;
		for (int i = 0; i < TN - 1; i++) begin
			if (!stop && i < int'(bank) - 1 && mid_item.rnd[i]) begin
				x = x - 1;
			end else begin
				stop = 1'b1;
			end
		end
		tgt    = '0;
		tgt_ok = 1'b0;
		for (int t = 0; t < TN; t++) begin
			if (t <= x && ent[t].useful == '0) begin
				tgt    = PROVIDER_BITS'(t);
				tgt_ok = 1'b1;
			end
		end

		c_new = prov.ctr;
		if (tk) begin
			if (prov.ctr != CMAX) begin
				c_new = prov.ctr + 1'b1;
			end
		end else if (prov.ctr != CMIN) begin
			c_new = prov.ctr - 1'b1;
		end
		u_new = mid_item.sweep ? (prov.useful & mid_item.keep) : prov.useful;
		if (pred != altp) begin
			if (pred == tk) begin
				if (u_new != 2'd3) begin
					u_new = u_new + 1'b1;
				end
			end else if (u_new != 2'd0) begin
				u_new = u_new - 1'b1;
			end
		end

		brow_new = brow;
		bstate   = {bim, brow[4]};
		if (tk == bim) begin
			brow_new[4] = tk;
		end else begin
			if (tk) begin
				if (bstate != 2'd3) begin
					bstate = bstate + 1'b1;
				end
			end else if (bstate != 2'd0) begin
				bstate = bstate - 1'b1;
			end
			brow_new[mid_item.bidx[1:0]] = bstate[1];
			brow_new[4] = bstate[0];
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		keep_d      = keep_q;
		skip_tab_d  = skip_tab_q;
		skip_addr_d = skip_addr_q;
		mid_pop     = 1'b0;
		out_push    = 1'b0;
		out_data    = '0;
		t_re        = 1'b0;
		t_we        = '0;
		b_re        = 1'b0;
		b_we        = 1'b0;
		b_ra        = mid_item.bidx[BIMODAL_INDEX_BITS-1:2];
		b_wa        = mid_item.bidx[BIMODAL_INDEX_BITS-1:2];
		b_wd        = brow_new;
		for (int t = 0; t < TN; t++) begin
			t_ra[t] = mid_item.idx[t];
			t_wa[t] = mid_item.idx[t];
			t_wd[t] = ent[t];
		end

		unique case (state_q)
			ST_CLEAR: begin
				for (int t = 0; t < TN; t++) begin
					t_we[t] = ((clr_q >> TIB) == '0);
					t_wa[t] = clr_q[TIB-1:0];
					t_wd[t] = '0;
				end
				b_we = ((clr_q >> BRW) == '0);
				b_wa = clr_q[BRW-1:0];
				b_wd = BROW_RESET;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (mid_valid) begin
					if (mid_item.cond) begin
						t_re    = 1'b1;
						b_re    = 1'b1;
						state_d = ST_EXEC;
					end else if (!out_full) begin
						out_push = 1'b1;
						mid_pop  = 1'b1;
					end
				end
			end
			ST_EXEC: begin
				if (!out_full) begin
					out_push                 = 1'b1;
					mid_pop                  = 1'b1;
					out_data.predicted_taken = pred;
					out_data.provider_table  = bank;
					out_data.alternate_taken = altp;
					for (int t = 0; t < TN; t++) begin
						if (found && PROVIDER_BITS'(t) == bank) begin
							t_we[t]        = 1'b1;
							t_wd[t].ctr    = c_new;
							t_wd[t].useful = u_new;
						end else if (alloc && PROVIDER_BITS'(t) < bank) begin
							if (!any_zero) begin
								t_we[t]        = 1'b1;
								t_wd[t].useful = ent[t].useful - 1'b1;
								if (mid_item.sweep) begin
									t_wd[t].useful = t_wd[t].useful & mid_item.keep;
								end
							end else if (tgt_ok && PROVIDER_BITS'(t) == tgt) begin
								t_we[t]        = 1'b1;
								t_wd[t].ctr    = tk ? '0 : '1;
								t_wd[t].tag    = mid_item.tag[t];
								t_wd[t].useful = '0;
							end
						end
					end
					b_we        = !found;
					keep_d      = mid_item.keep;
					skip_tab_d  = bank;
					skip_addr_d = mid_item.idx[bank[TI-1:0]];
					if (mid_item.sweep) begin
						cnt_d   = '0;
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SWEEP: begin
				// Read entry n while writing back entry n-1 with its useful bits masked.
				t_re = (cnt_q < (TIB+1)'(ENT));
				for (int t = 0; t < TN; t++) begin
					t_ra[t]        = cnt_q[TIB-1:0];
					t_wa[t]        = TIB'(cnt_q - 1'b1);
					t_wd[t].useful = ent[t].useful & keep_q;
					// The provider entry of the aging item already holds its final value.
					t_we[t] = (cnt_q != '0) && !(PROVIDER_BITS'(t) == skip_tab_q &&
						t_wa[t] == skip_addr_q);
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == (TIB+1)'(ENT)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			uac_q       <= '0;
			keep_q      <= '0;
			skip_tab_q  <= NONE;
			skip_addr_q <= '0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			keep_q      <= keep_d;
			skip_tab_q  <= skip_tab_d;
			skip_addr_q <= skip_addr_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_EXEC && !out_full) begin
				uac_q <= uac_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/tgbp_checker.sv =====
`default_nettype none
module tgbp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               push,
	input wire logic               full,
	input wire tgbp_pkg::request_t request,
	input wire logic               empty,
	input wire logic               pop,
	input wire tgbp_pkg::result_t  result
);

	// The tables are being cleared right after reset, so nothing goes in or out.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full && empty)
		else $error("predictor not quiet after reset");

	a_provider_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.provider_table <= 3'd4)
		else $error("provider table out of range");

	// With the bimodal base as provider there is no other source to pick from.
	a_base_alt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.provider_table == 3'd4 |->
		result.predicted_taken == result.alternate_taken)
		else $error("base prediction differs from alternate");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

endmodule

bind tagged_geometric_branch_predictor_unit tgbp_checker u_checker (.*);
`default_nettype wire
